### rtl/psd_pkg.sv
// Package for the pulse-gated steering drive.
// It holds the shared widths, register indexes, reset values and the
// controller-to-datapath command and status types. It has no dependencies.
package psd_pkg;

  localparam int ANGLE_W = 16;
  localparam int TIME_W  = 32;
  localparam int LEVEL_W = 8;
  localparam int SPAN_W  = 16;
  localparam int PROD_W  = SPAN_W + LEVEL_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W   = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_W    = ANGLE_W + TIME_W;
  localparam int OUT_W   = 2 * LEVEL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE_LOW  = 3'd0,
    REG_DEADZONE_HIGH = 3'd1,
    REG_LEFT_LIMIT    = 3'd2,
    REG_RIGHT_LIMIT   = 3'd3,
    REG_FULL_POWER    = 3'd4,
    REG_LOW_POWER     = 3'd5,
    REG_PULSE_PERIOD  = 3'd6,
    REG_PULSE_LENGTH  = 3'd7
  } cfg_idx_t;

  localparam logic signed [ANGLE_W-1:0] RST_DEADZONE_LOW  = -16'sd10;
  localparam logic signed [ANGLE_W-1:0] RST_DEADZONE_HIGH = 16'sd10;
  localparam logic signed [ANGLE_W-1:0] RST_LEFT_LIMIT    = -16'sd100;
  localparam logic signed [ANGLE_W-1:0] RST_RIGHT_LIMIT   = 16'sd100;
  localparam logic [LEVEL_W-1:0]        RST_FULL_POWER    = 8'd255;
  localparam logic [LEVEL_W-1:0]        RST_LOW_POWER     = 8'd102;
  localparam logic [15:0]               RST_PULSE_PERIOD  = 16'd100;
  localparam logic [15:0]               RST_PULSE_LENGTH  = 16'd50;

  // What the drive outputs should be for the current word.
  typedef enum logic [2:0] {
    KIND_ZERO   = 3'd0,
    KIND_FULL_L = 3'd1,
    KIND_FULL_R = 3'd2,
    KIND_LERP_L = 3'd3,
    KIND_LERP_R = 3'd4
  } kind_t;

  typedef struct packed {
    logic load;
    logic classify;
    logic mul;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic lerp;
    logic out_free;
  } status_t;

endpackage

### rtl/psd_ctrl.sv
// Controller for the pulse-gated steering drive.
// Sequences load, classify, multiply, divide and finish steps of the datapath.
// Depends on psd_pkg.
module psd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  psd_pkg::status_t  status,
  output psd_pkg::cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLASS = 5'b00010,
    S_MUL   = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                     state, state_next;
  logic [psd_pkg::CNT_W-1:0]  div_cnt, div_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    s_tready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        state_next   = S_MUL;
      end
      S_MUL: begin
        // Only interpolated levels need the multiply and divide.
        if (status.lerp) begin
          cmd.mul      = 1'b1;
          div_cnt_next = '0;
          state_next   = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == psd_pkg::CNT_W'(psd_pkg::DIV_STEPS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/psd_dp.sv
// Datapath for the pulse-gated steering drive.
// Holds the configuration registers, pulse gate state, multiplier, a
// restoring divider and the output register. Depends on psd_pkg.
module psd_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [psd_pkg::IN_W-1:0]          s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [psd_pkg::OUT_W-1:0]         m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [psd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  psd_pkg::cmd_t                     cmd,
  output psd_pkg::status_t                  status
);

  localparam int AW = psd_pkg::ANGLE_W;
  localparam int LW = psd_pkg::LEVEL_W;
  localparam int SW = psd_pkg::SPAN_W;
  localparam int PW = psd_pkg::PROD_W;
  localparam int TW = psd_pkg::TIME_W;
  localparam int RW = PW + 2;

  logic signed [AW-1:0] deadzone_low, deadzone_high, left_limit, right_limit;
  logic [LW-1:0]        full_power, low_power;
  logic [15:0]          pulse_period, pulse_length;

  logic [TW-1:0]        pulse_start_ms;
  logic                 pulse_on;
  logic signed [AW-1:0] angle;

  psd_pkg::kind_t       kind, kind_next;
  logic [SW-1:0]        dx, span;
  logic [LW-1:0]        mag, out_a;
  logic                 neg;
  logic [PW-1:0]        quot;
  logic [SW-1:0]        rem;

  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone_low  <= psd_pkg::RST_DEADZONE_LOW;
      deadzone_high <= psd_pkg::RST_DEADZONE_HIGH;
      left_limit    <= psd_pkg::RST_LEFT_LIMIT;
      right_limit   <= psd_pkg::RST_RIGHT_LIMIT;
      full_power    <= psd_pkg::RST_FULL_POWER;
      low_power     <= psd_pkg::RST_LOW_POWER;
      pulse_period  <= psd_pkg::RST_PULSE_PERIOD;
      pulse_length  <= psd_pkg::RST_PULSE_LENGTH;
    end else if (cfg_valid) begin
      unique case (psd_pkg::cfg_idx_t'(cfg_index))
        psd_pkg::REG_DEADZONE_LOW:  deadzone_low  <= cfg_data;
        psd_pkg::REG_DEADZONE_HIGH: deadzone_high <= cfg_data;
        psd_pkg::REG_LEFT_LIMIT:    left_limit    <= cfg_data;
        psd_pkg::REG_RIGHT_LIMIT:   right_limit   <= cfg_data;
        psd_pkg::REG_FULL_POWER:    full_power    <= cfg_data[LW-1:0];
        psd_pkg::REG_LOW_POWER:     low_power     <= cfg_data[LW-1:0];
        psd_pkg::REG_PULSE_PERIOD:  pulse_period  <= cfg_data;
        psd_pkg::REG_PULSE_LENGTH:  pulse_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pulse gate, updated as the word is taken.
  logic [TW-1:0] now_in, elapsed;
  assign now_in  = s_tdata[AW +: TW];
  assign elapsed = now_in - pulse_start_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_start_ms <= '0;
      pulse_on       <= 1'b0;
    end else if (cmd.load) begin
      if (elapsed > {16'b0, pulse_period}) begin
        pulse_on       <= 1'b1;
        pulse_start_ms <= now_in;
      end else if (elapsed > {16'b0, pulse_length}) begin
        pulse_on <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      angle <= s_tdata[AW-1:0];
    end
  end

  // Classification and interpolation operands.
  logic signed [AW:0]  lo_a, lo_b;
  logic [LW-1:0]       sel_a, sel_b;
  logic signed [AW:0]  dx_w, span_w;
  logic signed [LW:0]  odiff;
  logic [LW:0]         odiff_abs;

  always_comb begin
    kind_next = psd_pkg::KIND_ZERO;
    lo_a      = {left_limit[AW-1], left_limit};
    lo_b      = {deadzone_low[AW-1], deadzone_low};
    sel_a     = full_power;
    sel_b     = low_power;
    if (angle >= deadzone_low && angle <= deadzone_high) begin
      kind_next = psd_pkg::KIND_ZERO;
    end else if (!pulse_on) begin
      kind_next = psd_pkg::KIND_ZERO;
    end else if (angle < left_limit) begin
      kind_next = psd_pkg::KIND_FULL_L;
    end else if (angle < deadzone_low) begin
      kind_next = psd_pkg::KIND_LERP_L;
    end else if (angle > right_limit) begin
      kind_next = psd_pkg::KIND_FULL_R;
    end else if (angle > deadzone_high) begin
      kind_next = psd_pkg::KIND_LERP_R;
      lo_a      = {deadzone_high[AW-1], deadzone_high};
      lo_b      = {right_limit[AW-1], right_limit};
      sel_a     = low_power;
      sel_b     = full_power;
    end
    dx_w      = {angle[AW-1], angle} - lo_a;
    span_w    = lo_b - lo_a;
    odiff     = $signed({1'b0, sel_b}) - $signed({1'b0, sel_a});
    odiff_abs = odiff[LW] ? (~odiff + 1'b1) : odiff;
  end

  // On an interpolated path, dx lies in 0..span and span is positive.
  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= psd_pkg::KIND_ZERO;
    end else if (cmd.classify) begin
      kind <= kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      dx    <= dx_w[SW-1:0];
      span  <= span_w[SW-1:0];
      mag   <= odiff_abs[LW-1:0];
      neg   <= odiff[LW];
      out_a <= sel_a;
    end
  end

  assign status.lerp = (kind == psd_pkg::KIND_LERP_L) || (kind == psd_pkg::KIND_LERP_R);

  // Restoring divider: quot starts as the product and shifts in quotient bits.
  logic [SW:0] trial, trial_diff;
  logic        ge;
  assign trial      = {rem, quot[PW-1]};
  assign trial_diff = trial - {1'b0, span};
  assign ge         = (trial >= {1'b0, span});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      quot <= dx * mag;
      rem  <= '0;
    end else if (cmd.div_step) begin
      quot <= {quot[PW-2:0], ge};
      rem  <= ge ? trial_diff[SW-1:0] : trial[SW-1:0];
    end
  end

  // Final level: out_a plus the signed, truncated quotient, clamped to 0..255.
  logic signed [RW-1:0] q_s, lvl;
  logic [LW-1:0]        lvl_sat, right_lvl, left_lvl;

  always_comb begin
    q_s = $signed({2'b0, quot});
    if (neg) begin
      q_s = -q_s;
    end
    lvl = $signed({{(RW-LW){1'b0}}, out_a}) + q_s;
    if (lvl < 0) begin
      lvl_sat = '0;
    end else if (lvl > $signed(RW'(255))) begin
      lvl_sat = '1;
    end else begin
      lvl_sat = lvl[LW-1:0];
    end
    right_lvl = '0;
    left_lvl  = '0;
    case (kind)
      psd_pkg::KIND_FULL_L: left_lvl  = full_power;
      psd_pkg::KIND_FULL_R: right_lvl = full_power;
      psd_pkg::KIND_LERP_L: left_lvl  = lvl_sat;
      psd_pkg::KIND_LERP_R: right_lvl = lvl_sat;
      default: ;
    endcase
  end

  // Output register.
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {left_lvl, right_lvl};
    end
  end

endmodule

### rtl/pulse_gated_steering_drive.sv
// Pulse-gated steering drive, top level.
// Each input word holds a steering angle and the millisecond time; the block
// updates its drive pulse gate and returns one word with the two H-bridge
// levels.
//
// Channels: the s_ stream takes input words, the m_ stream returns results,
// and the cfg channel writes the eight setup registers by index. cfg_ready is
// always high.
// Steps: after acceptance each word is classified, then interpolated levels
// are multiplied and divided by the 24-step restoring divider, one quotient
// bit a cycle, before the result is registered. One word is worked on at a
// time and s_tready returns as the result is registered, so no new word is
// taken while one is in progress.
// A finished result waits in the output register while the next word is
// taken; if the receiver still stalls when that word is finished, the block
// holds it and s_tready stays low until the output register frees.
// Reset clears the pulse gate (pulse off, start time zero), loads the default
// register values and empties the output register.
// Depends on psd_pkg, psd_ctrl and psd_dp.
module pulse_gated_steering_drive (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [psd_pkg::IN_W-1:0]        s_tdata,   // angle[15:0], now_ms[47:16]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [psd_pkg::OUT_W-1:0]       m_tdata,   // drive_right[7:0], drive_left[15:8]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  psd_pkg::cmd_t    cmd;
  psd_pkg::status_t status;

  psd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  psd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

### tb/pulse_gated_steering_drive_tb.sv
// Self-checking testbench for the pulse-gated steering drive.
// A scoreboard class predicts the pulse gate and the drive levels for each
// accepted word and checks every result word; it depends on psd_pkg and the RTL.
module pulse_gated_steering_drive_tb;

  // Result word layout, lowest bits first: drive_right, drive_left.
  typedef struct packed {
    logic [7:0] drive_left;
    logic [7:0] drive_right;
  } levels_t;

  class steering_scoreboard;
    shortint     dz_lo, dz_hi, lim_l, lim_r;
    logic [7:0]  full_pw, low_pw;
    logic [15:0] period, length;
    logic [31:0] pulse_start;
    bit          pulse_on;
    levels_t     levels_q[$];
    int          errors;

    function new();
      dz_lo       = psd_pkg::RST_DEADZONE_LOW;
      dz_hi       = psd_pkg::RST_DEADZONE_HIGH;
      lim_l       = psd_pkg::RST_LEFT_LIMIT;
      lim_r       = psd_pkg::RST_RIGHT_LIMIT;
      full_pw     = psd_pkg::RST_FULL_POWER;
      low_pw      = psd_pkg::RST_LOW_POWER;
      period      = psd_pkg::RST_PULSE_PERIOD;
      length      = psd_pkg::RST_PULSE_LENGTH;
      pulse_start = '0;
      pulse_on    = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(psd_pkg::cfg_idx_t idx, logic [15:0] val);
      case (idx)
        psd_pkg::REG_DEADZONE_LOW:  dz_lo = val;
        psd_pkg::REG_DEADZONE_HIGH: dz_hi = val;
        psd_pkg::REG_LEFT_LIMIT:    lim_l = val;
        psd_pkg::REG_RIGHT_LIMIT:   lim_r = val;
        psd_pkg::REG_FULL_POWER:    full_pw = val[7:0];
        psd_pkg::REG_LOW_POWER:     low_pw = val[7:0];
        psd_pkg::REG_PULSE_PERIOD:  period = val;
        psd_pkg::REG_PULSE_LENGTH:  length = val;
        default: ;
      endcase
    endfunction

    // Straight line from lvl_a at a toward lvl_b at b, truncated toward zero.
    function logic [7:0] interp(int x, int a, int b, int lvl_a, int lvl_b);
      longint span, lvl;
      span = longint'(b) - a;
      if (span <= 0) return lvl_a[7:0];
      lvl = (longint'(x) - a) * (longint'(lvl_b) - lvl_a) / span + lvl_a;
      if (lvl < 0) lvl = 0;
      if (lvl > 255) lvl = 255;
      return lvl[7:0];
    endfunction

    function void note_input(shortint angle, logic [31:0] now_ms);
      logic [31:0] elapsed;
      levels_t     lv;
      elapsed = now_ms - pulse_start;
      // The gate moves on every word, deadzone angles included.
      if (elapsed > {16'h0, period}) begin
        pulse_on    = 1'b1;
        pulse_start = now_ms;
      end else if (elapsed > {16'h0, length}) begin
        pulse_on = 1'b0;
      end
      lv = '0;
      if (!(angle >= dz_lo && angle <= dz_hi) && pulse_on) begin
        if (angle < lim_l)
          lv.drive_left = full_pw;
        else if (angle < dz_lo)
          lv.drive_left = interp(angle, lim_l, dz_lo, full_pw, low_pw);
        else if (angle > lim_r)
          lv.drive_right = full_pw;
        else if (angle > dz_hi)
          lv.drive_right = interp(angle, dz_hi, lim_r, low_pw, full_pw);
      end
      levels_q.push_back(lv);
    endfunction

    function void check_result(logic [15:0] word);
      levels_t got, want;
      got = word;
      if (levels_q.size() == 0) begin
        $error("result word 0x%04h arrived with no expectation waiting", word);
        errors++;
        return;
      end
      want = levels_q.pop_front();
      if (got.drive_right !== want.drive_right) begin
        $error("drive_right mismatch: expected %0d, actual %0d",
               want.drive_right, got.drive_right);
        errors++;
      end
      if (got.drive_left !== want.drive_left) begin
        $error("drive_left mismatch: expected %0d, actual %0d",
               want.drive_left, got.drive_left);
        errors++;
      end
    endfunction

    function int pending();
      return levels_q.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [psd_pkg::IN_W-1:0]       s_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [psd_pkg::OUT_W-1:0]      m_tdata;
  logic                           cfg_valid;
  logic                           cfg_ready;
  psd_pkg::cfg_idx_t              cfg_index;
  logic [psd_pkg::CFG_DATA_W-1:0] cfg_data;

  steering_scoreboard sb;
  logic [31:0]        clock_ms;
  bit                 tx_steady;
  bit                 rx_steady;
  int                 rx_hold;

  pulse_gated_steering_drive dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    if (!rst && s_tvalid && s_tready) sb.note_input(s_tdata[15:0], s_tdata[47:16]);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls, or a long hold-off when the stimulus asks.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
        m_tready <= 1'b1;
      end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (1 + pick_gap()) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_item(input shortint angle, input logic [31:0] now_ms);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {now_ms, angle};
    do @(posedge clk); while (!s_tready);
  endtask

  // Angles cluster around the region edges so every branch gets hit.
  function automatic shortint pick_angle();
    int base;
    case ($urandom_range(0, 5))
      0: base = sb.dz_lo;
      1: base = sb.dz_hi;
      2: base = sb.lim_l;
      3: base = sb.lim_r;
      default: return shortint'($urandom);
    endcase
    if ($urandom_range(0, 1))
      base += int'($urandom_range(0, 8)) - 4;
    else
      base += int'($urandom_range(0, 600)) - 300;
    return shortint'(base);
  endfunction

  task automatic send_random_item();
    int unsigned step;
    if ($urandom_range(0, 9) == 0) begin
      send_item(shortint'($urandom), $urandom);
    end else begin
      // Time steps land near the pulse length and period to toggle the gate.
      case ($urandom_range(0, 7))
        0, 1, 2: step = $urandom_range(0, 8);
        3:       step = sb.length + $urandom_range(0, 2);
        4:       step = sb.period + $urandom_range(0, 2);
        5:       step = $urandom_range(0, sb.period);
        6:       step = $urandom_range(0, 300);
        default: step = $urandom;
      endcase
      clock_ms = clock_ms + step;
      send_item(pick_angle(), clock_ms);
    end
  endtask

  task automatic cfg_write(input psd_pkg::cfg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input shortint dzl, input shortint dzh,
                              input shortint ll, input shortint lr,
                              input logic [7:0] fp, input logic [7:0] lp,
                              input logic [15:0] per, input logic [15:0] len);
    cfg_write(psd_pkg::REG_DEADZONE_LOW, dzl);
    cfg_write(psd_pkg::REG_DEADZONE_HIGH, dzh);
    cfg_write(psd_pkg::REG_LEFT_LIMIT, ll);
    cfg_write(psd_pkg::REG_RIGHT_LIMIT, lr);
    // The upper byte of the 8-bit levels must be ignored.
    cfg_write(psd_pkg::REG_FULL_POWER, {8'($urandom), fp});
    cfg_write(psd_pkg::REG_LOW_POWER, {8'($urandom), lp});
    cfg_write(psd_pkg::REG_PULSE_PERIOD, per);
    cfg_write(psd_pkg::REG_PULSE_LENGTH, len);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_ordered();
    int dzl, dzh;
    dzl = -int'($urandom_range(0, 60));
    dzh = int'($urandom_range(0, 60));
    program_regs(shortint'(dzl), shortint'(dzh),
                 shortint'(dzl - int'($urandom_range(1, 400))),
                 shortint'(dzh + int'($urandom_range(1, 400))),
                 8'($urandom), 8'($urandom),
                 16'($urandom_range(4, 200)), 16'($urandom_range(0, 150)));
  endtask

  task automatic drain_and_wait();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  initial begin
    sb = new();
    clock_ms  = '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    rx_hold   = 0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= psd_pkg::REG_DEADZONE_LOW;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words on the reset settings; the gate starts off at time zero.
    send_item(0, 0);
    send_item(50, 100);            // elapsed equals the period: still off
    send_item(50, 101);            // pulse starts, right interpolation
    send_item(-50, 110);
    send_item(-32768, 120);
    send_item(32767, 125);
    send_item(-100, 130);          // exactly on the left limit
    send_item(100, 135);           // exactly on the right limit
    send_item(-101, 140);
    send_item(101, 141);
    send_item(-11, 142);
    send_item(11, 143);
    send_item(-10, 144);
    send_item(10, 145);
    send_item(200, 151);           // elapsed equals the length: stays on
    send_item(200, 152);           // pulse ends
    send_item(-200, 201);
    send_item(-200, 202);          // next pulse starts
    send_item(5, 32'hFFFF_FFF0);   // deadzone word still restarts the pulse
    send_item(-200, 32'h0000_0010); // elapsed wraps through zero
    send_item(300, 32'hFFFF_FFFF);
    send_item(-30, 32'h0000_0040);
    clock_ms = 32'h0000_0040;

    for (int phase = 0; phase < 9; phase++) begin
      drain_and_wait();
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      case (phase)
        1: program_ordered();
        2: begin
          program_ordered();
          tx_steady = 1'b1;
          rx_steady = 1'b1;
        end
        3: program_regs(-1, 0, -32768, 32767, 8'd255, 8'd0, 16'd0, 16'd0);
        4: program_regs(-32768, 32767, -32768, 32767, 8'd0, 8'd0,
                        16'hFFFF, 16'hFFFF);
        5: begin
          program_regs(shortint'($urandom), shortint'($urandom),
                       shortint'($urandom), shortint'($urandom),
                       8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
          clock_ms = 32'hFFFF_FF00;
        end
        // Crossed limits and an empty deadzone.
        6: program_regs(20, -20, 50, -50, 8'd200, 8'd10, 16'd30, 16'd10);
        7: begin
          program_ordered();
          rx_hold   = 300;
          tx_steady = 1'b1;
          repeat (12) send_random_item();
          tx_steady = 1'b0;
          drain_and_wait();
        end
        8: program_regs(shortint'($urandom), shortint'($urandom),
                        shortint'($urandom), shortint'($urandom),
                        8'($urandom), 8'($urandom),
                        16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)));
        default: ;
      endcase
      repeat (50) send_random_item();
    end

    drain_and_wait();
    if (sb.pending() != 0) begin
      $error("%0d expected result words never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
